// ----- design/hfd_pkg.sv -----
// shared types and constants for the hundredths fixed-point divider
package hfd_pkg;

    localparam int WHOLE_W  = 32;
    localparam int HUND_W   = 7;
    localparam int N2_W     = 40;
    localparam int Q10_FRAC = 10;
    localparam int Q8_FRAC  = 8;

    localparam logic [HUND_W-1:0] HUNDRED  = 7'd100;
    localparam logic [HUND_W-1:0] MAX_HUND = 7'd99;

    typedef enum logic [1:0] {
        KIND_Q22_10 = 2'd0,
        KIND_Q24_8  = 2'd1,
        KIND_DIVIDE = 2'd2
    } t_kind;

    // travels beside the divider data down the pipe
    typedef struct packed {
        logic                is_div;
        logic                dz;
        logic [WHOLE_W-1:0]  cv_whole;
        logic [HUND_W-1:0]   cv_hund;
    } t_side;

endpackage

// ----- design/hundredths_fixed_point_divider_unit.sv -----
// top level: whole.hundredths conversions and divide, fully pipelined
// result strobe o_done is registered from the last valid flop of the divider pipe
// throughput: one word per cycle, busy stays low; 32 whole-quotient stages,
// one multiply stage and 7 hundredths stages set the depth
// reset: synchronous active-low i_rst_n clears every valid bit and the strobe
// the receiver cannot stall, so the pipe never holds
module hundredths_fixed_point_divider_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_kind,
    input  logic [hfd_pkg::WHOLE_W-1:0] i_raw_fixed,
    input  logic [hfd_pkg::WHOLE_W-1:0] i_whole_in,
    input  logic [hfd_pkg::HUND_W-1:0]  i_hundredths_in,
    input  logic [hfd_pkg::WHOLE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [hfd_pkg::WHOLE_W-1:0] o_whole_out,
    output logic [hfd_pkg::HUND_W-1:0]  o_hundredths_out,
    output logic                        o_divide_by_zero
);
    import hfd_pkg::*;

    logic [Q10_FRAC+HUND_W-1:0] w_p10;
    logic [Q8_FRAC+HUND_W-1:0]  w_p8;
    logic [HUND_W-1:0]          w_hin;
    logic                       w_dvs_zero;
    logic                       w_accept;
    t_side                      w_side;

    logic                       w_core_vld;
    logic [WHOLE_W-1:0]         w_core_quo;
    logic [HUND_W-1:0]          w_core_fq;
    t_side                      w_core_side;

    logic                       r_done;
    logic [WHOLE_W-1:0]         r_whole;
    logic [HUND_W-1:0]          r_hund;
    logic                       r_dz;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_comb begin
        w_p10      = (Q10_FRAC+HUND_W)'(i_raw_fixed[Q10_FRAC-1:0]) * (Q10_FRAC+HUND_W)'(HUNDRED);
        w_p8       = (Q8_FRAC+HUND_W)'(i_raw_fixed[Q8_FRAC-1:0]) * (Q8_FRAC+HUND_W)'(HUNDRED);
        w_hin      = (i_hundredths_in > MAX_HUND) ? MAX_HUND : i_hundredths_in;
        w_dvs_zero = (i_divisor == '0);

        w_side = '0;
        case (t_kind'(i_kind))
            KIND_Q22_10: begin
                w_side.cv_whole = WHOLE_W'(i_raw_fixed >> Q10_FRAC);
                w_side.cv_hund  = w_p10[Q10_FRAC+HUND_W-1:Q10_FRAC];
            end
            KIND_Q24_8: begin
                w_side.cv_whole = WHOLE_W'(i_raw_fixed >> Q8_FRAC);
                w_side.cv_hund  = w_p8[Q8_FRAC+HUND_W-1:Q8_FRAC];
            end
            KIND_DIVIDE: begin
                w_side.is_div = !w_dvs_zero;
                w_side.dz     = w_dvs_zero;
            end
            default: begin
                w_side = '0;
            end
        endcase
    end

    hfd_div_pipe u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (w_accept),
        .i_dividend (i_whole_in),
        .i_divisor  (i_divisor),
        .i_hund     (w_hin),
        .i_side     (w_side),
        .o_vld      (w_core_vld),
        .o_quo      (w_core_quo),
        .o_fq       (w_core_fq),
        .o_side     (w_core_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_core_vld;
        end
    end

    // divider result only for a real divide, else the precomputed word
    always_ff @(posedge i_clk) begin
        r_whole <= w_core_side.is_div ? w_core_quo : w_core_side.cv_whole;
        r_hund  <= w_core_side.is_div ? w_core_fq  : w_core_side.cv_hund;
        r_dz    <= w_core_side.dz;
    end

    assign o_done           = r_done;
    assign o_whole_out      = r_whole;
    assign o_hundredths_out = r_hund;
    assign o_divide_by_zero = r_dz;

    a_hund_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hundredths_out <= MAX_HUND))
        else $error("hundredths result above 99");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_divide_by_zero) |-> (o_whole_out == '0 && o_hundredths_out == '0))
        else $error("zero-divisor result not zero");

    a_core_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_core_vld |=> o_done)
        else $error("divider word lost before the output register");

    a_div_hund: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_core_vld && w_core_side.is_div) |-> (w_core_fq <= MAX_HUND))
        else $error("hundredths quotient overflow");

endmodule

// ----- design/hfd_div_pipe.sv -----
// restoring divider pipeline: one quotient bit per divide stage, whole part then hundredths
module hfd_div_pipe (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [hfd_pkg::WHOLE_W-1:0] i_dividend,
    input  logic [hfd_pkg::WHOLE_W-1:0] i_divisor,
    input  logic [hfd_pkg::HUND_W-1:0]  i_hund,
    input  hfd_pkg::t_side              i_side,
    output logic                        o_vld,
    output logic [hfd_pkg::WHOLE_W-1:0] o_quo,
    output logic [hfd_pkg::HUND_W-1:0]  o_fq,
    output hfd_pkg::t_side              o_side
);
    import hfd_pkg::*;

    localparam int WS   = WHOLE_W;
    localparam int MS   = WS + 1;
    localparam int LAST = MS + HUND_W;

    logic               r_vld  [0:LAST];
    logic [WHOLE_W-1:0] r_dvs  [0:LAST];
    logic [WHOLE_W-1:0] r_quo  [0:LAST];
    t_side              r_side [0:LAST];
    logic [WHOLE_W-1:0] r_dvd  [0:WS];
    logic [WHOLE_W-1:0] r_rem  [0:WS];
    logic [HUND_W-1:0]  r_hin  [0:WS];
    logic [N2_W-1:0]    r_n2   [MS:LAST];
    logic [HUND_W-1:0]  r_fq   [MS:LAST];

    // capture stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvs[0]  <= i_divisor;
        r_quo[0]  <= '0;
        r_side[0] <= i_side;
        r_dvd[0]  <= i_dividend;
        r_rem[0]  <= '0;
        r_hin[0]  <= i_hund;
    end

    // one valid flop per stage after capture, shifting with the data
    genvar k;
    generate
        for (k = 0; k < LAST; k++) begin : g_vld
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else begin
                    r_vld[k+1] <= r_vld[k];
                end
            end
        end

        // whole part: one bit per stage
        for (k = 0; k < WS; k++) begin : g_whole
            logic [WHOLE_W:0] n_trial;
            logic [WHOLE_W:0] n_diff;
            logic             n_ge;

            always_comb begin
                n_trial = {r_rem[k], r_dvd[k][WHOLE_W-1]};
                n_diff  = n_trial - {1'b0, r_dvs[k]};
                n_ge    = n_trial >= {1'b0, r_dvs[k]};
            end

            always_ff @(posedge i_clk) begin
                r_dvs[k+1]  <= r_dvs[k];
                r_side[k+1] <= r_side[k];
                r_hin[k+1]  <= r_hin[k];
                r_dvd[k+1]  <= {r_dvd[k][WHOLE_W-2:0], 1'b0};
                r_rem[k+1]  <= n_ge ? n_diff[WHOLE_W-1:0] : n_trial[WHOLE_W-1:0];
                r_quo[k+1]  <= {r_quo[k][WHOLE_W-2:0], n_ge};
            end
        end
    endgenerate

    // remainder * 100 + hundredths, at full width so it never wraps
    always_ff @(posedge i_clk) begin
        r_dvs[MS]  <= r_dvs[WS];
        r_side[MS] <= r_side[WS];
        r_quo[MS]  <= r_quo[WS];
        r_n2[MS]   <= N2_W'(r_rem[WS]) * N2_W'(HUNDRED) + N2_W'(r_hin[WS]);
        r_fq[MS]   <= '0;
    end

    // hundredths quotient: at most 99, so seven shifted-divisor steps
    genvar j;
    generate
        for (j = 0; j < HUND_W; j++) begin : g_frac
            logic [N2_W-1:0] n_sh;
            logic            n_ge;

            always_comb begin
                n_sh = N2_W'(r_dvs[MS+j]) << (HUND_W - 1 - j);
                n_ge = r_n2[MS+j] >= n_sh;
            end

            always_ff @(posedge i_clk) begin
                r_dvs[MS+j+1]  <= r_dvs[MS+j];
                r_side[MS+j+1] <= r_side[MS+j];
                r_quo[MS+j+1]  <= r_quo[MS+j];
                r_n2[MS+j+1]   <= n_ge ? (r_n2[MS+j] - n_sh) : r_n2[MS+j];
                r_fq[MS+j+1]   <= {r_fq[MS+j][HUND_W-2:0], n_ge};
            end
        end
    endgenerate

    assign o_vld  = r_vld[LAST];
    assign o_quo  = r_quo[LAST];
    assign o_fq   = r_fq[LAST];
    assign o_side = r_side[LAST];

endmodule
